// ===== design/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// spl_pkg: shared types and constants of the spectrum peak level colour block
// Holds the register map, the configuration and level word types, and the
// fixed-point helper that divides a color product by full scale.
// ----------------------------------------------------------------------------
package spl_pkg;

  // Full level in 16-bit fixed point (10.0 of the original scale).
  localparam logic [15:0] FULL_SCALE = 16'd65280;

  // Bins beyond this count in one frame are ignored.
  localparam logic [7:0] MAX_BINS = 8'd128;

  // Register index, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_MAXIMUM_MODE = 3'd0,
    REG_START_BIN    = 3'd1,
    REG_END_BIN      = 3'd2,
    REG_THRESHOLD    = 3'd3,
    REG_FADE_STEP    = 3'd4,
    REG_BASE_COLOUR  = 3'd5
  } reg_idx_t;

  // Settings that the frame accumulator needs.
  typedef struct packed {
    logic        maximum_mode;
    logic [7:0]  start_bin;
    logic [7:0]  end_bin;
    logic [7:0]  threshold;
    logic [15:0] fade_step;
  } frame_cfg_t;

  // Level word handed from the frame accumulator to the color scaler.
  typedef struct packed {
    logic        valid;
    logic [15:0] level;
  } level_word_t;

  // Exact floor(x / 65280) for x up to 255 * 65280. 65280 = 256 * 255, so the
  // low byte is dropped first and the rest is divided by 255 with the usual
  // add-and-shift identity, exact for 16-bit dividends.
  function automatic logic [7:0] div_full_scale(input logic [23:0] x);
    logic [16:0] sum;
    sum = {1'b0, x[23:8]} + {9'd0, x[23:16]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

// ===== design/spl_frame.sv =====
// ----------------------------------------------------------------------------
// spl_frame: bin input register, running peak and held level
// Registers each incoming bin, tracks the frame peak and bin count, and on the
// last bin of an output frame applies threshold and fade to produce the level.
// ----------------------------------------------------------------------------
module spl_frame
  import spl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  frame_cfg_t  cfg,
  input  logic        bin_valid,
  output logic        bin_stall,
  input  logic [15:0] bin_magnitude,
  input  logic        last_bin,
  input  logic        output_frame,
  output level_word_t lvl,
  input  logic        lvl_take
);

  // Input register.
  logic        a_valid;
  logic [15:0] a_mag;
  logic        a_last;
  logic        a_emit;

  // Frame state.
  logic [15:0] frame_peak;
  logic [7:0]  bins_seen;
  logic [15:0] held_level;

  // Level register.
  logic        b_valid;
  logic [15:0] b_level;

  logic        a_res;
  logic        a_move;
  logic        accept;
  logic [15:0] mag_sat;
  logic        counting;
  logic [7:0]  pos;
  logic        included;
  logic [15:0] peak_next;
  logic [7:0]  bins_next;
  logic [15:0] raw_level;
  logic [15:0] thr_level;
  logic [15:0] faded;
  logic [15:0] level_next;

  assign a_res     = a_last && a_emit;
  assign a_move    = a_valid && (!a_res || !b_valid || lvl_take);
  assign bin_stall = a_valid && !a_move;
  assign accept    = bin_valid && !bin_stall;

  always_comb begin
    mag_sat   = (a_mag > FULL_SCALE) ? FULL_SCALE : a_mag;
    counting  = bins_seen < MAX_BINS;
    pos       = bins_seen + 8'd1;
    included  = counting && (pos >= cfg.start_bin) && (pos <= cfg.end_bin);
    peak_next = (included && (mag_sat > frame_peak)) ? mag_sat : frame_peak;
    bins_next = counting ? pos : bins_seen;
    raw_level = (cfg.maximum_mode && (bins_next >= cfg.end_bin)) ? peak_next : 16'd0;
    thr_level = (raw_level < {cfg.threshold, 8'd0}) ? 16'd0 : raw_level;
    faded     = held_level - cfg.fade_step;
    if ((held_level > cfg.fade_step) && (faded > thr_level)) begin
      level_next = faded;
    end else begin
      level_next = thr_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_mag  <= bin_magnitude;
      a_last <= last_bin;
      a_emit <= output_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_peak <= '0;
      bins_seen  <= '0;
      held_level <= '0;
    end else if (a_move) begin
      if (a_last) begin
        frame_peak <= '0;
        bins_seen  <= '0;
      end else begin
        frame_peak <= peak_next;
        bins_seen  <= bins_next;
      end
      if (a_res) begin
        held_level <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move && a_res) begin
      b_valid <= 1'b1;
    end else if (lvl_take) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move && a_res) begin
      b_level <= level_next;
    end
  end

  assign lvl.valid = b_valid;
  assign lvl.level = b_level;

endmodule

// ===== design/spl_scale.sv =====
// ----------------------------------------------------------------------------
// spl_scale: color scaling and output register
// Multiplies each color byte by the level, then divides by full scale into the
// output register that drives the pixel channel.
// ----------------------------------------------------------------------------
module spl_scale
  import spl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [23:0] base_colour,
  input  level_word_t lvl,
  output logic        lvl_take,
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [15:0] level
);

  // Product register.
  logic        p_valid;
  logic [23:0] p_red;
  logic [23:0] p_green;
  logic [23:0] p_blue;
  logic [15:0] p_level;

  // Output register.
  logic        o_valid;

  logic        o_free;
  logic        p_move;
  logic        p_free;

  assign o_free   = !o_valid || !pix_stall;
  assign p_move   = p_valid && o_free;
  assign p_free   = !p_valid || p_move;
  assign lvl_take = lvl.valid && p_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= lvl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_take) begin
      p_red   <= base_colour[23:16] * lvl.level;
      p_green <= base_colour[15:8] * lvl.level;
      p_blue  <= base_colour[7:0] * lvl.level;
      p_level <= lvl.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_free) begin
      o_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      red   <= div_full_scale(p_red);
      green <= div_full_scale(p_green);
      blue  <= div_full_scale(p_blue);
      level <= p_level;
    end
  end

  assign pix_valid = o_valid;

endmodule

// ===== design/spectrum_peak_level_colour_top.sv =====
// ----------------------------------------------------------------------------
// spectrum_peak_level_colour_top: color organ peak level meter with decay
// Takes spectrum bins one word at a time, keeps the peak over a bin window,
// and per output frame emits a decaying level and the base color scaled by it.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                     payload
//   bin       in         bin_valid / bin_stall          bin_magnitude, last_bin,
//                                                       output_frame
//   pix       out        pix_valid / pix_stall          red, green, blue, level
//   config    in         APB psel/penable/pwrite/pready paddr[4:0], pwdata/prdata
//
// One bin word is accepted every cycle when the output side keeps up. A word
// passes the input register, the level register, the product register and the
// output register before its result word is presented on the pixel channel.
// held_level takes the same value as the level register in the same cycle,
// which is what allows frames of a single bin to follow each other directly.
// Reset is synchronous and active high; it clears all valid flags, the frame
// state and the configuration registers to their defaults. A stall on the pixel
// side fills the pipeline from the output back; words that produce no result
// still drain through the input register while a result waits downstream.
//
module spectrum_peak_level_colour_top
  import spl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Bin input channel.
  input  logic        bin_valid,
  output logic        bin_stall,
  input  logic [15:0] bin_magnitude,
  input  logic        last_bin,
  input  logic        output_frame,
  // Pixel output channel.
  output logic        pix_valid,
  input  logic        pix_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [15:0] level,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic        maximum_mode;
  logic [7:0]  start_bin;
  logic [7:0]  end_bin;
  logic [7:0]  threshold;
  logic [15:0] fade_step;
  logic [23:0] base_colour;

  logic        cfg_write;
  reg_idx_t    cfg_idx;
  frame_cfg_t  frame_cfg;
  level_word_t lvl;
  logic        lvl_take;

  // The register file answers in the access cycle; there are no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      maximum_mode <= 1'b0;
      start_bin    <= 8'd1;
      end_bin      <= 8'd127;
      threshold    <= 8'd80;
      fade_step    <= FULL_SCALE;
      base_colour  <= 24'hFFFFFF;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_MAXIMUM_MODE: maximum_mode <= pwdata[0];
        REG_START_BIN:    start_bin    <= pwdata[7:0];
        REG_END_BIN:      end_bin      <= pwdata[7:0];
        REG_THRESHOLD:    threshold    <= pwdata[7:0];
        REG_FADE_STEP:    fade_step    <= pwdata[15:0];
        REG_BASE_COLOUR:  base_colour  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Reads return the stored value; unmapped addresses read as zero.
  always_comb begin
    case (cfg_idx)
      REG_MAXIMUM_MODE: prdata = {31'd0, maximum_mode};
      REG_START_BIN:    prdata = {24'd0, start_bin};
      REG_END_BIN:      prdata = {24'd0, end_bin};
      REG_THRESHOLD:    prdata = {24'd0, threshold};
      REG_FADE_STEP:    prdata = {16'd0, fade_step};
      REG_BASE_COLOUR:  prdata = {8'd0, base_colour};
      default:          prdata = 32'd0;
    endcase
  end

  assign frame_cfg.maximum_mode = maximum_mode;
  assign frame_cfg.start_bin    = start_bin;
  assign frame_cfg.end_bin      = end_bin;
  assign frame_cfg.threshold    = threshold;
  assign frame_cfg.fade_step    = fade_step;

  // Peak tracking, threshold and fade.
  spl_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .cfg           (frame_cfg),
    .bin_valid     (bin_valid),
    .bin_stall     (bin_stall),
    .bin_magnitude (bin_magnitude),
    .last_bin      (last_bin),
    .output_frame  (output_frame),
    .lvl           (lvl),
    .lvl_take      (lvl_take)
  );

  // Color scaling and output register.
  spl_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .base_colour (base_colour),
    .lvl         (lvl),
    .lvl_take    (lvl_take),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .level       (level)
  );

endmodule

// ===== design/spl_checker.sv =====
// ----------------------------------------------------------------------------
// spl_checker: port-level checks for the spectrum peak level colour block
// Watches the top-level ports and flags results that the block cannot produce.
// ----------------------------------------------------------------------------
module spl_checker
  import spl_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        pix_valid,
  input logic        pix_stall,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [15:0] level
);

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("result word present after reset");

  // The held level never exceeds full scale.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> (level <= FULL_SCALE))
    else $error("level above full scale");

  // A zero level scales every color component to zero.
  a_zero_dark: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && (level == 16'd0)) |-> ((red == 8'd0) && (green == 8'd0) && (blue == 8'd0)))
    else $error("color present at zero level");

  // A stalled result word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && pix_stall) |=> (pix_valid && $stable(red) && $stable(green)
                                  && $stable(blue) && $stable(level)))
    else $error("stalled result word changed");

endmodule

bind spectrum_peak_level_colour_top spl_checker u_spl_checker (.*);

// ===== test/spectrum_peak_level_colour_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum_peak_level_colour_top_tb: self-checking bench for the peak meter
// Streams spectrum frames into the bin channel under random gaps and output
// stalls, predicts every pixel word from a local model of the meter, and
// compares each accepted pixel word field by field in arrival order.
// ----------------------------------------------------------------------------
module spectrum_peak_level_colour_top_tb;
  import spl_pkg::*;

  // Cycles without any accepted word (bin, pixel or register write) before the
  // run is declared hung. The slowest correct stretch is a long stall on top
  // of a long gap plus the settle time around register writes, well below this limit.
  localparam int WATCHDOG_LIMIT = 2000;
  // This margin covers the pipeline depth with room to spare.
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 570;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] level;
  } pixel_t;

  typedef logic [15:0] mag_list_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        bin_valid = 1'b0;
  logic        bin_stall;
  logic [15:0] bin_magnitude = '0;
  logic        last_bin = 1'b0;
  logic        output_frame = 1'b0;
  logic        pix_valid;
  logic        pix_stall = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] level;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  spectrum_peak_level_colour_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .bin_valid    (bin_valid),
    .bin_stall    (bin_stall),
    .bin_magnitude(bin_magnitude),
    .last_bin     (last_bin),
    .output_frame (output_frame),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .level        (level),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // Local copy of the register file, starting from the reset defaults.
  logic        set_mode = 1'b0;
  logic [7:0]  set_start = 8'd1;
  logic [7:0]  set_stop = 8'd127;
  logic [7:0]  set_threshold = 8'd80;
  logic [15:0] set_fade = 16'd65280;
  logic [23:0] set_colour = 24'hFFFFFF;

  // Meter state: running peak of the frame, bins counted so far, held level.
  logic [15:0] meter_peak = '0;
  logic [7:0]  meter_bins = '0;
  logic [15:0] meter_held = '0;

  pixel_t expected_pixels[$];
  int     mismatches = 0;
  int     random_items = 0;
  int     quiet_cycles = 0;

  // Idling behavior: 0 keeps the side busy every cycle, 1 inserts random gaps.
  int source_mode = 0;
  int sink_mode = 0;
  int stall_left = 0;

  // Mostly short pauses with an occasional long one.
  function automatic int pick_pause_length();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [7:0] scale_colour(input logic [7:0] c, input logic [15:0] lvl);
    int unsigned product;
    product = c * lvl;
    return 8'(product / 32'(FULL_SCALE));
  endfunction

  // Advances the meter by one accepted bin word and queues the pixel word
  // that the frame produces, if any.
  function automatic void advance_meter(input logic [15:0] mag_in, input logic last,
                                        input logic emit);
    logic [15:0] mag;
    logic [15:0] lvl;
    int          pos;
    pixel_t      pix;
    mag = (mag_in > FULL_SCALE) ? FULL_SCALE : mag_in;
    // Bins beyond the first MAX_BINS of a frame leave the peak and count alone.
    if (meter_bins < MAX_BINS) begin
      pos = int'(meter_bins) + 1;
      if (pos >= int'(set_start) && pos <= int'(set_stop) && mag > meter_peak)
        meter_peak = mag;
      meter_bins = 8'(pos);
    end
    if (!last)
      return;
    // A frame shorter than the window end yields a zero level.
    lvl = (set_mode && meter_bins >= set_stop) ? meter_peak : 16'd0;
    meter_peak = '0;
    meter_bins = '0;
    if (!emit)
      return;
    if (lvl < {set_threshold, 8'h00})
      lvl = '0;
    // The held level never falls faster than the fade step allows.
    if (meter_held > set_fade && (meter_held - set_fade) > lvl)
      lvl = meter_held - set_fade;
    meter_held = lvl;
    pix.red = scale_colour(set_colour[23:16], lvl);
    pix.green = scale_colour(set_colour[15:8], lvl);
    pix.blue = scale_colour(set_colour[7:0], lvl);
    pix.level = lvl;
    expected_pixels.push_back(pix);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Drives one bin word, optionally after a gap, and waits until it is taken.
  // Valid stays high after acceptance so back-to-back words need no bubble.
  task automatic send_bin(input logic [15:0] mag, input logic last, input logic emit);
    int gap;
    gap = 0;
    if (source_mode != 0 && $urandom_range(0, 99) < 35)
      gap = pick_pause_length();
    @(negedge clk);
    if (gap > 0) begin
      bin_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    bin_valid <= 1'b1;
    bin_magnitude <= mag;
    last_bin <= last;
    output_frame <= emit;
    do @(posedge clk); while (bin_stall);
    advance_meter(mag, last, emit);
  endtask

  task automatic send_frame(input mag_list_t mags, input logic emit);
    foreach (mags[i])
      send_bin(mags[i], i == mags.size() - 1, emit);
  endtask

  // Lowers valid and waits until every predicted pixel word has come back.
  task automatic drain_results();
    @(negedge clk);
    bin_valid <= 1'b0;
    while (expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  // Frames that emit nothing may still be in flight when the queue empties,
  // so the pipeline is given its full depth before any register changes.
  task automatic quiesce();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MAXIMUM_MODE: set_mode = value[0];
      REG_START_BIN:    set_start = value[7:0];
      REG_END_BIN:      set_stop = value[7:0];
      REG_THRESHOLD:    set_threshold = value[7:0];
      REG_FADE_STEP:    set_fade = value[15:0];
      REG_BASE_COLOUR:  set_colour = value[23:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_settings(input logic mode, input logic [7:0] start_b,
                                input logic [7:0] stop_b, input logic [7:0] thr,
                                input logic [15:0] fade, input logic [23:0] colour);
    quiesce();
    write_register(REG_MAXIMUM_MODE, 32'(mode));
    write_register(REG_START_BIN, 32'(start_b));
    write_register(REG_END_BIN, 32'(stop_b));
    write_register(REG_THRESHOLD, 32'(thr));
    write_register(REG_FADE_STEP, 32'(fade));
    write_register(REG_BASE_COLOUR, 32'(colour));
  endtask

  // With the reset settings maximum mode is off, so every level is zero.
  task automatic test_reset_defaults();
    send_frame('{16'd65535, 16'd1000, 16'd0}, 1'b1);
    send_frame('{16'd500}, 1'b1);
  endtask

  // Window of bins two to four: the first bin is outside it, and magnitudes
  // above full scale saturate.
  task automatic test_peak_window();
    apply_settings(1'b1, 8'd2, 8'd4, 8'd0, 16'hFFFF, 24'hFFFFFF);
    send_frame('{16'd65535, 16'd65281, 16'd12, 16'd0}, 1'b1);
    send_frame('{16'd0, 16'h8000, 16'h1234, 16'h00FF}, 1'b1);
    send_frame('{16'hFFFF, 16'h0001, 16'h7FFF, 16'hFF00}, 1'b1);
  endtask

  task automatic test_special_cases();
    apply_settings(1'b1, 8'd1, 8'd4, 8'd0, 16'hFFFF, 24'h80FF01);
    // A frame shorter than the window end gives zero.
    send_frame('{16'd40000, 16'd40000, 16'd40000}, 1'b1);
    // A last bin without output_frame clears the frame but emits nothing.
    send_frame('{16'd65280, 16'd65280, 16'd65280, 16'd65280}, 1'b0);
    send_frame('{16'd1, 16'd1, 16'd1, 16'd1}, 1'b1);
    // Start after end includes no bin.
    apply_settings(1'b1, 8'd5, 8'd3, 8'd0, 16'hFFFF, 24'h123456);
    send_frame('{16'd60000, 16'd60000, 16'd60000, 16'd60000, 16'd60000}, 1'b1);
    // Start bin zero behaves as bin one.
    apply_settings(1'b1, 8'd0, 8'd2, 8'd0, 16'hFFFF, 24'hFEDCBA);
    send_frame('{16'd40000, 16'd100}, 1'b1);
    // End bin zero includes no bin.
    apply_settings(1'b1, 8'd1, 8'd0, 8'd0, 16'hFFFF, 24'hFFFFFF);
    send_frame('{16'd40000, 16'd40000}, 1'b1);
  endtask

  // Single-bin frames back to back: threshold edge, then decay by the fade
  // step, then a fade of zero that holds the level, then maximum mode off.
  task automatic test_threshold_and_fade();
    apply_settings(1'b1, 8'd1, 8'd1, 8'h40, 16'd1000, 24'hFFFFFF);
    send_frame('{16'h3FFF}, 1'b1);
    send_frame('{16'h4000}, 1'b1);
    send_frame('{16'd0}, 1'b1);
    send_frame('{16'd0}, 1'b1);
    send_frame('{16'h4100}, 1'b1);
    apply_settings(1'b1, 8'd1, 8'd1, 8'hFF, 16'd0, 24'h00FF80);
    send_frame('{16'd0}, 1'b1);
    send_frame('{16'd65280}, 1'b1);
    apply_settings(1'b0, 8'd1, 8'd1, 8'd0, 16'hFFFF, 24'hFFFFFF);
    send_frame('{16'd65280}, 1'b1);
  endtask

  // Frames longer than MAX_BINS: bins past the limit are ignored, so full
  // scale there never raises the peak.
  task automatic test_overlong_frame();
    apply_settings(1'b1, 8'd120, 8'd128, 8'd0, 16'hFFFF, 24'hFFFFFF);
    for (int i = 1; i <= 150; i++)
      send_bin((i == 125) ? 16'd30000 : (i > 128 ? 16'hFFFF : 16'd7), i == 150, 1'b1);
    apply_settings(1'b1, 8'd1, 8'd255, 8'd0, 16'hFFFF, 24'hFFFFFF);
    for (int i = 1; i <= 140; i++)
      send_bin(16'd50000, i == 140, 1'b1);
  endtask

  function automatic logic [15:0] random_magnitude();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      return 16'($urandom_range(65270, 65535));
    if (r < 22)
      return 16'($urandom_range(0, 255));
    return 16'($urandom());
  endfunction

  task automatic random_settings();
    logic [7:0]  start_b;
    logic [7:0]  stop_b;
    logic [7:0]  thr;
    logic [15:0] fade;
    logic [23:0] colour;
    int          r;
    r = $urandom_range(0, 99);
    stop_b = (r < 75) ? 8'($urandom_range(1, 12)) :
             (r < 85) ? 8'd128 : (r < 90) ? 8'd0 : (r < 94) ? 8'd255 : 8'($urandom());
    r = $urandom_range(0, 99);
    start_b = (r < 70) ? 8'($urandom_range(1, (stop_b == 0) ? 1 : int'(stop_b))) :
              (r < 80) ? 8'd0 : (r < 88) ? 8'd128 : (r < 93) ? 8'd255 : 8'($urandom());
    r = $urandom_range(0, 99);
    thr = (r < 60) ? 8'($urandom_range(0, 60)) : (r < 75) ? 8'd0 :
          (r < 85) ? 8'd255 : 8'($urandom());
    r = $urandom_range(0, 99);
    fade = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : (r < 40) ? 16'd65280 :
           (r < 75) ? 16'($urandom_range(1, 4000)) : 16'($urandom());
    r = $urandom_range(0, 99);
    colour = (r < 10) ? 24'hFFFFFF : (r < 18) ? 24'h000000 : 24'($urandom());
    apply_settings($urandom_range(0, 99) < 85, start_b, stop_b, thr, fade, colour);
  endtask

  // Phases of random settings and idling, each carrying a burst of frames
  // whose length mostly sits near the window end so both full and short
  // frames are common. Now and then the sender waits for every result.
  task automatic test_random_frames();
    int phase_items;
    int len;
    int r;
    while (random_items < RANDOM_ITEMS) begin
      random_settings();
      source_mode = $urandom_range(0, 2) != 0;
      sink_mode = $urandom_range(0, 2) != 0;
      phase_items = 0;
      while (phase_items < 120 && random_items < RANDOM_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 70)
          len = int'(set_stop) + int'($urandom_range(0, 5)) - 2;
        else if (r < 95)
          len = $urandom_range(1, 16);
        else
          len = $urandom_range(125, 140);
        if (len < 1)
          len = 1;
        if (len > 140)
          len = 140;
        for (int i = 1; i <= len; i++)
          send_bin(random_magnitude(), i == len, $urandom_range(0, 99) < 85);
        phase_items += len;
        random_items += len;
        if ($urandom_range(0, 99) < 5)
          drain_results();
      end
    end
  endtask

  // Output side: random stalls while sink_mode is set.
  always @(negedge clk) begin
    if (rst) begin
      pix_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pix_stall <= 1'b1;
    end else if (sink_mode != 0 && $urandom_range(0, 99) < 30) begin
      stall_left <= pick_pause_length() - 1;
      pix_stall <= 1'b1;
    end else begin
      pix_stall <= 1'b0;
    end
  end

  // Compares every accepted pixel word against the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pix_valid && !pix_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel word with none expected, level", level, -1);
      end else begin
        want = expected_pixels.pop_front();
        if (red !== want.red)
          report_mismatch("red", red, want.red);
        if (green !== want.green)
          report_mismatch("green", green, want.green);
        if (blue !== want.blue)
          report_mismatch("blue", blue, want.blue);
        if (level !== want.level)
          report_mismatch("level", level, want.level);
      end
    end
  end

  // Watchdog: any accepted word on any port counts as progress.
  always @(posedge clk) begin
    if (rst || (bin_valid && !bin_stall) || (pix_valid && !pix_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d pixel words outstanding", expected_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    source_mode = 1;
    sink_mode = 1;
    test_peak_window();
    test_special_cases();
    source_mode = 0;
    sink_mode = 0;
    test_threshold_and_fade();
    sink_mode = 1;
    test_overlong_frame();
    test_random_frames();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch("pixel words never delivered", 0, expected_pixels.size());
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/spl_pkg.sv
design/spl_frame.sv
design/spl_scale.sv
design/spectrum_peak_level_colour_top.sv
design/spl_checker.sv
test/spectrum_peak_level_colour_top_tb.sv
